// ----- hw/rtl/rgbpwm_pkg.sv -----
`timescale 1ns / 1ps

package rgbpwm_pkg;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_BUTTON  = 2'd1;
    localparam logic [1:0] ACT_COMMAND = 2'd2;

    localparam logic [31:0] DEBOUNCE_RESET = 32'd125000;
    localparam logic [1:0]  STEP_RESET     = 2'd2;
    localparam logic [1:0]  STEP_RED       = 2'd0;
    localparam logic [1:0]  STEP_GREEN     = 2'd1;
    localparam logic [1:0]  STEP_LAST      = 2'd2;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [7:0] DUTY_FULL = 8'd255;
    localparam logic [7:0] DUTY_HALF = 8'd128;
    localparam logic [7:0] DUTY_OFF  = 8'd0;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } duty_t;

    typedef struct packed {
        logic red;
        logic green;
        logic blue;
    } led_t;

    typedef struct packed {
        logic [7:0]  phase;
        logic [31:0] tick_count;
        logic [31:0] last_press;
        logic [1:0]  colour_step;
        duty_t       duty;
    } state_t;

    function automatic duty_t preset_duty(input logic [3:0] k);
        duty_t d;
        case (k)
            4'd0:    d = '{DUTY_OFF,  DUTY_OFF,  DUTY_OFF};
            4'd1:    d = '{DUTY_FULL, DUTY_OFF,  DUTY_OFF};
            4'd2:    d = '{DUTY_OFF,  DUTY_FULL, DUTY_OFF};
            4'd3:    d = '{DUTY_OFF,  DUTY_OFF,  DUTY_FULL};
            4'd4:    d = '{DUTY_FULL, DUTY_FULL, DUTY_OFF};
            4'd5:    d = '{DUTY_OFF,  DUTY_FULL, DUTY_FULL};
            4'd6:    d = '{DUTY_FULL, DUTY_OFF,  DUTY_FULL};
            4'd7:    d = '{DUTY_FULL, DUTY_FULL, DUTY_FULL};
            4'd8:    d = '{DUTY_FULL, DUTY_HALF, DUTY_OFF};
            4'd9:    d = '{DUTY_HALF, DUTY_OFF,  DUTY_HALF};
            default: d = '{DUTY_OFF,  DUTY_OFF,  DUTY_OFF};
        endcase
        return d;
    endfunction

    function automatic duty_t step_duty(input logic [1:0] step);
        duty_t d;
        case (step)
            STEP_RED:   d = '{DUTY_FULL, DUTY_OFF,  DUTY_OFF};
            STEP_GREEN: d = '{DUTY_OFF,  DUTY_FULL, DUTY_OFF};
            default:    d = '{DUTY_OFF,  DUTY_OFF,  DUTY_FULL};
        endcase
        return d;
    endfunction

endpackage

// ----- hw/rtl/rgbpwm_in_if.sv -----
`timescale 1ns / 1ps

interface rgbpwm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] byte_value;

    modport source (output valid, output action, output byte_value, input ready);
    modport sink (input valid, input action, input byte_value, output ready);
endinterface

// ----- hw/rtl/rgbpwm_out_if.sv -----
`timescale 1ns / 1ps

interface rgbpwm_out_if;
    logic valid;
    logic ready;
    logic led_red;
    logic led_green;
    logic led_blue;

    modport source (output valid, output led_red, output led_green, output led_blue,
                    input ready);
    modport sink (input valid, input led_red, input led_green, input led_blue,
                  output ready);
endinterface

// ----- hw/rtl/rgbpwm_core.sv -----
`timescale 1ns / 1ps

module rgbpwm_core (
    input  logic                take,
    input  logic [1:0]          action,
    input  logic [7:0]          byte_value,
    input  logic [31:0]         debounce_ticks,
    input  rgbpwm_pkg::state_t  state,
    output rgbpwm_pkg::state_t  state_next,
    output logic                push,
    output rgbpwm_pkg::led_t    leds
);
    import rgbpwm_pkg::*;

    logic [7:0]  phase_inc;
    logic [31:0] elapsed;
    logic [1:0]  step_inc;
    logic [3:0]  preset_off;
    logic        is_digit;

    assign phase_inc  = state.phase + 8'd1;
    assign elapsed    = state.tick_count - state.last_press;
    assign step_inc   = (state.colour_step >= STEP_LAST) ? STEP_RED
                                                         : state.colour_step + 2'd1;
    assign preset_off = byte_value[3:0] - CHAR_ZERO[3:0];
    assign is_digit   = (byte_value >= CHAR_ZERO) && (byte_value <= CHAR_NINE);

    assign leds.red   = !(phase_inc < state.duty.red);
    assign leds.green = !(phase_inc < state.duty.green);
    assign leds.blue  = !(phase_inc < state.duty.blue);

    always_comb
    begin
        state_next = state;
        push       = 1'b0;
        if (take)
        begin
            case (action)
                ACT_TICK:
                begin
                    state_next.phase      = phase_inc;
                    state_next.tick_count = state.tick_count + 32'd1;
                    push                  = 1'b1;
                end
                ACT_BUTTON:
                begin
                    if (elapsed > debounce_ticks)
                    begin
                        state_next.colour_step = step_inc;
                        state_next.duty        = step_duty(step_inc);
                        state_next.last_press  = state.tick_count;
                    end
                end
                ACT_COMMAND:
                begin
                    if (is_digit)
                    begin
                        state_next.duty = preset_duty(preset_off);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/rgb_led_pwm_color_controller_top.sv -----
`timescale 1ns / 1ps

// Three-channel PWM controller for an RGB LED.
// The item channel carries one action per transfer: a timer tick, a button
// press or a command byte. Every tick transfer advances the PWM phase and
// the tick count and produces one transfer on the result channel with the
// three LED line levels; button and command transfers produce no result.
// Each result is registered in the result register before it is offered.
// The item channel takes one transfer every cycle while the skid register
// is empty, set by the single pass of compare and increment logic between
// the state and result registers. When the receiver stalls, the result
// register holds its value and a skid register catches one further result;
// the item channel then drops ready until the result register drains.
// The debounce setting is written through cfg_wr_en and cfg_wr_data and
// should only change while the block is idle.
// Reset clears the phase, tick count, press time and duties, sets the
// colour step so that the first accepted press gives red, loads the
// default debounce setting and empties both result registers.

module rgb_led_pwm_color_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    rgbpwm_in_if.sink   item,
    rgbpwm_out_if.source result
);
    import rgbpwm_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    logic [31:0] debounce_reg;
    logic        take;
    logic        push;
    led_t        push_leds;
    logic        out_valid_reg;
    led_t        out_reg;
    logic        skid_valid_reg;
    led_t        skid_reg;

    assign item.ready = !skid_valid_reg;
    assign take       = item.valid && item.ready;

    rgbpwm_core u_core (
        .take           (take),
        .action         (item.action),
        .byte_value     (item.byte_value),
        .debounce_ticks (debounce_reg),
        .state          (state_reg),
        .state_next     (state_next),
        .push           (push),
        .leds           (push_leds)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_wr_en)
        begin
            debounce_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= 8'd0;
            state_reg.tick_count  <= 32'd0;
            state_reg.last_press  <= 32'd0;
            state_reg.colour_step <= STEP_RESET;
            state_reg.duty        <= '{DUTY_OFF, DUTY_OFF, DUTY_OFF};
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : push_leds;
        end
        else if (push)
        begin
            skid_reg <= push_leds;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.led_red   = out_reg.red;
    assign result.led_green = out_reg.green;
    assign result.led_blue  = out_reg.blue;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while result register empty");

    a_phase_tracks_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == state_reg.tick_count[7:0])
        else $error("PWM phase out of step with tick count");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.action == ACT_TICK)
        |=> state_reg.phase == 8'($past(state_reg.phase) + 8'd1))
        else $error("tick transfer did not advance the phase");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result.ready && push))
        else $error("skid register filled without a stalled result");

    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.action == ACT_TICK) |=> (out_valid_reg || skid_valid_reg))
        else $error("tick transfer produced no pending result");
`endif

endmodule

// ----- verif/rgb_led_pwm_color_controller_top_tb.sv -----
`timescale 1ns / 1ps

module rgb_led_pwm_color_controller_top_tb;
    import rgbpwm_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam int         STALL_LIMIT = 2000;
    localparam int         HOLD_CYCLES = 64;
    localparam int         PHASE_ITEMS = 360;

    localparam duty_t PRESET_DUTY [10] = '{
        '{DUTY_OFF,  DUTY_OFF,  DUTY_OFF},
        '{DUTY_FULL, DUTY_OFF,  DUTY_OFF},
        '{DUTY_OFF,  DUTY_FULL, DUTY_OFF},
        '{DUTY_OFF,  DUTY_OFF,  DUTY_FULL},
        '{DUTY_FULL, DUTY_FULL, DUTY_OFF},
        '{DUTY_OFF,  DUTY_FULL, DUTY_FULL},
        '{DUTY_FULL, DUTY_OFF,  DUTY_FULL},
        '{DUTY_FULL, DUTY_FULL, DUTY_FULL},
        '{DUTY_FULL, DUTY_HALF, DUTY_OFF},
        '{DUTY_HALF, DUTY_OFF,  DUTY_HALF}
    };

    class led_scoreboard;
        logic [7:0]  phase;
        logic [31:0] ticks;
        logic [31:0] last_press;
        logic [31:0] debounce;
        logic [1:0]  colour_step;
        duty_t       duty;
        led_t        leds_due[$];
        int          errors;

        function new();
            phase = '0;
            ticks = '0;
            last_press = '0;
            debounce = DEBOUNCE_RESET;
            colour_step = STEP_RESET;
            duty = '0;
            errors = 0;
        endfunction

        function void set_debounce(logic [31:0] value);
            debounce = value;
        endfunction

        function int pending();
            return leds_due.size();
        endfunction

        function void note_item(logic [1:0] act, logic [7:0] value);
            logic [31:0] elapsed;
            led_t        leds;
            case (act)
                ACT_TICK:
                begin
                    phase = phase + 8'd1;
                    ticks = ticks + 32'd1;
                    leds.red = (phase < duty.red) ? 1'b0 : 1'b1;
                    leds.green = (phase < duty.green) ? 1'b0 : 1'b1;
                    leds.blue = (phase < duty.blue) ? 1'b0 : 1'b1;
                    leds_due.push_back(leds);
                end
                ACT_BUTTON:
                begin
                    elapsed = ticks - last_press;
                    if (elapsed > debounce)
                    begin
                        colour_step = (colour_step >= STEP_LAST) ? STEP_RED : colour_step + 2'd1;
                        duty.red = (colour_step == STEP_RED) ? DUTY_FULL : DUTY_OFF;
                        duty.green = (colour_step == STEP_GREEN) ? DUTY_FULL : DUTY_OFF;
                        duty.blue = (colour_step == STEP_LAST) ? DUTY_FULL : DUTY_OFF;
                        last_press = ticks;
                    end
                end
                ACT_COMMAND:
                begin
                    if (value >= CHAR_ZERO && value <= CHAR_NINE)
                        duty = PRESET_DUTY[4'(value - CHAR_ZERO)];
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_line(string colour, logic want, logic got);
            if (got !== want)
            begin
                $display("%0t: %s line mismatch, expected %b, actual %b",
                         $time, colour, want, got);
                errors++;
            end
        endfunction

        function void check_result(led_t got);
            led_t want;
            if (leds_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual r%b g%b b%b",
                         $time, got.red, got.green, got.blue);
                errors++;
                return;
            end
            want = leds_due.pop_front();
            compare_line("red", want.red, got.red);
            compare_line("green", want.green, got.green);
            compare_line("blue", want.blue, got.blue);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    rgbpwm_in_if  item_ch ();
    rgbpwm_out_if result_ch ();

    rgb_led_pwm_color_controller_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (result_ch)
    );

    led_scoreboard sb;
    bit            idle_on;
    bit            hold_request;
    int            hold_left;
    int            stall_cycles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_item(input logic [1:0] act, input logic [7:0] value);
        int gap;
        gap = (idle_on && $urandom_range(99) < 15) ? 1 : 0;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.action <= act;
        item_ch.byte_value <= value;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_item(act, value);
    endtask

    task automatic send_random_item();
        int          pick;
        logic [1:0]  act;
        logic [7:0]  value;
        pick = $urandom_range(99);
        value = 8'($urandom_range(255));
        if (pick < 50)
            act = ACT_TICK;
        else if (pick < 65)
            act = ACT_BUTTON;
        else if (pick < 90)
        begin
            act = ACT_COMMAND;
            if ($urandom_range(3) != 0)
                value = CHAR_ZERO + 8'($urandom_range(9));
        end
        else
            act = ACT_UNUSED;
        send_item(act, value);
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_debounce(input logic [31:0] value);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        sb.set_debounce(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_directed();
        int k;
        send_item(ACT_TICK, 8'hFF);
        send_item(ACT_TICK, 8'h00);
        send_item(ACT_BUTTON, 8'hAA);
        send_item(ACT_COMMAND, CHAR_CR);
        send_item(ACT_COMMAND, CHAR_LF);
        send_item(ACT_COMMAND, CHAR_ZERO - 8'd1);
        send_item(ACT_COMMAND, CHAR_NINE + 8'd1);
        send_item(ACT_COMMAND, 8'hFF);
        send_item(ACT_UNUSED, CHAR_ZERO + 8'd7);
        for (k = 0; k < 10; k++)
        begin
            send_item(ACT_COMMAND, CHAR_ZERO + 8'(k));
            send_item(ACT_TICK, 8'h55);
        end
    endtask

    task automatic run_random(input int phase_no);
        int i;
        for (i = 0; i < PHASE_ITEMS; i++)
        begin
            idle_on = !((phase_no == 1 && i < 150) || (phase_no == 0 && i >= 40 && i < 120));
            if (phase_no == 0 && i == 40)
                hold_request = 1'b1;
            if (i == 200)
                drain_results();
            send_random_item();
        end
    endtask

    initial
    begin
        logic [31:0] settings [5];
        int          p;
        sb = new();
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        item_ch.valid <= 1'b0;
        item_ch.action <= ACT_TICK;
        item_ch.byte_value <= '0;
        idle_on = 1'b1;
        hold_request = 1'b0;
        settings[0] = 32'd0;
        settings[1] = 32'hFFFF_FFFF;
        settings[2] = $urandom_range(1, 6);
        settings[3] = $urandom;
        settings[4] = 32'd2;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (p = 0; p < 5; p++)
        begin
            write_debounce(settings[p]);
            run_random(p);
        end
        drain_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        result_ch.ready <= 1'b0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                sb.check_result('{result_ch.led_red, result_ch.led_green, result_ch.led_blue});
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= !(idle_on && $urandom_range(99) < 15);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (item_ch.valid && item_ch.ready)
            || (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
